>>> hw/rtl/stt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stt_pkg: shared types and codes of the timer table
// Entry layout, cell command, controller states, opcodes and result kinds.
// ---------------------------------------------------------------------------
package stt_pkg;

    localparam int DEFAULT_SLOTS = 16;

    localparam int TIME_W   = 32;
    localparam int HANDLE_W = 31;
    localparam int IDENT_W  = 32;

    // opcodes on the input tuser
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // result kinds on the output tuser
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;
    localparam logic [1:0] KIND_NOFIRE = 2'd3;

    typedef struct packed {
        logic                periodic;
        logic [TIME_W-1:0]   interval;
        logic [TIME_W-1:0]   due;
        logic [HANDLE_W-1:0] handle;
        logic [IDENT_W-1:0]  ident;
    } entry_t;

    // shift: whole chain moves one cell toward the head
    // put:   the cell at the write position takes the write data
    typedef struct packed {
        logic shift;
        logic put;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/stt_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stt_cell: one timer slot
// Holds one entry; shifts in from its neighbor or loads the write data.
// ---------------------------------------------------------------------------
module stt_cell
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  wire                 clk,
    input  stt_pkg::cell_cmd_t  cmd,
    input  wire [CNT_W-1:0]     pos,
    input  stt_pkg::entry_t     wdata,
    input  stt_pkg::entry_t     shift_in,
    output stt_pkg::entry_t     q
);
    import stt_pkg::*;

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;

    assign hit = cmd.put && (pos == MY_POS);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.shift)
        begin
            entry_next = hit ? wdata : shift_in;
        end
        else if (hit)
        begin
            entry_next = wdata;
        end
    end

    // payload only, no reset needed; liveness is tracked by the fill count
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

>>> hw/rtl/stt_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stt_ctrl: sequencer of the timer table
// Takes a command, walks the head of the cell chain, builds the results.
// ---------------------------------------------------------------------------
module stt_ctrl
#(
    parameter int TIMER_SLOTS = stt_pkg::DEFAULT_SLOTS,
    parameter int CNT_W       = $clog2(TIMER_SLOTS + 1)
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    // command side
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire [1:0]                    in_op,
    input  wire [stt_pkg::TIME_W-1:0]    in_now,
    input  wire [stt_pkg::TIME_W-1:0]    in_interval,
    input  wire                          in_periodic,
    input  wire [stt_pkg::HANDLE_W-1:0]  in_handle,
    input  wire [stt_pkg::IDENT_W-1:0]   in_target,
    // result side
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [1:0]                   out_kind,
    output logic                         out_success,
    output logic [stt_pkg::IDENT_W-1:0]  out_id,
    output logic [stt_pkg::HANDLE_W-1:0] out_handle,
    output logic                         out_last,
    // cell chain
    input  stt_pkg::entry_t              head,
    output stt_pkg::cell_cmd_t           cmd,
    output logic [CNT_W-1:0]             pos,
    output stt_pkg::entry_t              wdata
);
    import stt_pkg::*;

    localparam logic [CNT_W-1:0] FULL = CNT_W'(TIMER_SLOTS);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    state_t state_reg, state_next;

    logic [1:0]          op_reg, op_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   ivl_reg, ivl_next;
    logic                per_reg, per_next;
    logic [HANDLE_W-1:0] hnd_reg, hnd_next;
    logic [IDENT_W-1:0]  tgt_reg, tgt_next;

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [IDENT_W-1:0]  ident_reg, ident_next;
    logic                found_reg, found_next;

    logic                pend_valid_reg, pend_valid_next;
    logic [IDENT_W-1:0]  pend_id_reg, pend_id_next;
    logic [HANDLE_W-1:0] pend_hnd_reg, pend_hnd_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic                out_ok_reg, out_ok_next;
    logic [IDENT_W-1:0]  out_id_reg, out_id_next;
    logic [HANDLE_W-1:0] out_hnd_reg, out_hnd_next;
    logic                out_last_reg, out_last_next;

    logic                out_free;
    logic                accept;
    logic                step;
    logic [TIME_W-1:0]   late;
    logic                fire;
    logic                match;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign step     = (state_reg == ST_SCAN) && (scan_reg != '0) && out_free;
    assign late     = now_reg - head.due;
    assign fire     = !late[TIME_W-1];
    assign match    = !found_reg && (head.ident == tgt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_ADD:    state_next = ST_ADD;
                        OP_TICK:   state_next = ST_SCAN;
                        OP_REMOVE: state_next = ST_SCAN;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_reg == '0)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next         = op_reg;
        now_next        = now_reg;
        ivl_next        = ivl_reg;
        per_next        = per_reg;
        hnd_next        = hnd_reg;
        tgt_next        = tgt_reg;
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        ident_next      = ident_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_hnd_next   = pend_hnd_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = out_kind_reg;
        out_ok_next     = out_ok_reg;
        out_id_next     = out_id_reg;
        out_hnd_next    = out_hnd_reg;
        out_last_next   = out_last_reg;
        cmd             = '0;
        pos             = cnt_reg - ONE;
        wdata           = head;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = in_op;
                    now_next        = in_now;
                    ivl_next        = in_interval;
                    per_next        = in_periodic;
                    hnd_next        = in_handle;
                    tgt_next        = in_target;
                    scan_next       = cnt_reg;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_ADD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ADD;
                    out_hnd_next   = '0;
                    out_last_next  = 1'b1;
                    if (cnt_reg != FULL)
                    begin
                        cmd.put        = 1'b1;
                        pos            = cnt_reg;
                        wdata.periodic = per_reg;
                        wdata.interval = ivl_reg;
                        wdata.due      = now_reg + ivl_reg;
                        wdata.handle   = hnd_reg;
                        wdata.ident    = ident_reg;
                        cnt_next       = cnt_reg + ONE;
                        ident_next     = ident_reg + IDENT_W'(1);
                        out_ok_next    = 1'b1;
                        out_id_next    = ident_reg;
                    end
                    else
                    begin
                        out_ok_next = 1'b0;
                        out_id_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    // head leaves the chain; kept entries re-enter behind the live ones
                    cmd.shift = 1'b1;
                    scan_next = scan_reg - ONE;
                    if (op_reg == OP_TICK)
                    begin
                        if (fire)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_FIRED;
                                out_ok_next    = 1'b1;
                                out_id_next    = pend_id_reg;
                                out_hnd_next   = pend_hnd_reg;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_id_next    = head.ident;
                            pend_hnd_next   = head.handle;
                            if (head.periodic)
                            begin
                                cmd.put   = 1'b1;
                                wdata.due = now_reg + head.interval;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - ONE;
                            end
                        end
                        else
                        begin
                            cmd.put = 1'b1;
                        end
                    end
                    else
                    begin
                        if (match)
                        begin
                            found_next = 1'b1;
                            cnt_next   = cnt_reg - ONE;
                        end
                        else
                        begin
                            cmd.put = 1'b1;
                        end
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_id_next    = '0;
                    out_hnd_next   = '0;
                    if (op_reg == OP_TICK)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_kind_next = KIND_FIRED;
                            out_ok_next   = 1'b1;
                            out_id_next   = pend_id_reg;
                            out_hnd_next  = pend_hnd_reg;
                        end
                        else
                        begin
                            out_kind_next = KIND_NOFIRE;
                            out_ok_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        out_kind_next = KIND_REMOVE;
                        out_ok_next   = found_reg;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            ident_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            scan_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ident_reg      <= ident_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            scan_reg       <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        ivl_reg      <= ivl_next;
        per_reg      <= per_next;
        hnd_reg      <= hnd_next;
        tgt_reg      <= tgt_next;
        pend_id_reg  <= pend_id_next;
        pend_hnd_reg <= pend_hnd_next;
        out_kind_reg <= out_kind_next;
        out_ok_reg   <= out_ok_next;
        out_id_reg   <= out_id_next;
        out_hnd_reg  <= out_hnd_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_success = out_ok_reg;
    assign out_id      = out_id_reg;
    assign out_handle  = out_hnd_reg;
    assign out_last    = out_last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/software_timer_table_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// software_timer_table_top: table of one-shot and periodic timers
// Add, remove and tick commands over a chain of timer slot cells.
// ---------------------------------------------------------------------------
//
//  channel  | direction | tuser        | tdata                     | tlast
//  ---------+-----------+--------------+---------------------------+-------
//  s_axis   | in        | opcode       | now, interval, periodic,  | -
//           |           |              | handle, target id (128b)  |
//  m_axis   | out       | result kind  | success, id, handle (64b) | last
//
//  Steps: an add is accepted, then stored and answered in ST_ADD; a tick
//  or remove is accepted, then shifts each live slot past the head in
//  turn, then leaves the scan and sends the final result. An
//  unused opcode is dropped in its accept cycle. Each result sits in one
//  output register; the scan waits while that register is held by
//  m_axis_tready. Reset clears the fill count, the id counter and all
//  handshake state; slot contents are not reset. No clearing pass.
//
// Live timers sit packed in cells 0..count-1, oldest in cell 0. A tick or
// remove moves every live entry once through the head: the head entry is
// examined and either written back behind the other live entries or
// dropped, so creation order and packing are kept without a gap-closing
// pass. A fired result is held back one step so that the final one can be
// marked last.
// ---------------------------------------------------------------------------
module software_timer_table_top
#(
    parameter int TIMER_SLOTS = stt_pkg::DEFAULT_SLOTS
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // [127:96] target_id, [95:65] callback_handle, [64] periodic,
    // [63:32] interval_ms, [31:0] now_ms
    input  wire [127:0]  s_axis_tdata,
    // [1:0] opcode
    input  wire [1:0]    s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [63:33] fired_handle, [32:1] timer_id, [0] success
    output logic [63:0]  m_axis_tdata,
    // [1:0] result_kind
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import stt_pkg::*;

    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    cell_cmd_t           cmd;
    logic [CNT_W-1:0]    pos;
    entry_t              wdata;
    entry_t              q [TIMER_SLOTS];

    logic                res_success;
    logic [IDENT_W-1:0]  res_id;
    logic [HANDLE_W-1:0] res_handle;

    stt_ctrl
    #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .CNT_W       (CNT_W)
    )
    u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tuser),
        .in_now      (s_axis_tdata[31:0]),
        .in_interval (s_axis_tdata[63:32]),
        .in_periodic (s_axis_tdata[64]),
        .in_handle   (s_axis_tdata[95:65]),
        .in_target   (s_axis_tdata[127:96]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_kind    (m_axis_tuser),
        .out_success (res_success),
        .out_id      (res_id),
        .out_handle  (res_handle),
        .out_last    (m_axis_tlast),
        .head        (q[0]),
        .cmd         (cmd),
        .pos         (pos),
        .wdata       (wdata)
    );

    // slot chain: each cell but the tail takes its upper neighbor on a shift; the tail keeps its own
    for (genvar i = 0; i < TIMER_SLOTS; i++)
    begin : g_cell
        entry_t nb;
        if (i == TIMER_SLOTS - 1)
        begin : g_tail
            assign nb = q[i];
        end
        else
        begin : g_body
            assign nb = q[i+1];
        end

        stt_cell
        #(
            .IDX   (i),
            .CNT_W (CNT_W)
        )
        u_cell
        (
            .clk      (clk),
            .cmd      (cmd),
            .pos      (pos),
            .wdata    (wdata),
            .shift_in (nb),
            .q        (q[i])
        );
    end

    assign m_axis_tdata = {res_handle, res_id, res_success};

endmodule

`default_nettype wire

>>> test/software_timer_table_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// software_timer_table_top_tb: self-checking bench for the timer table
// Sends add, remove, tick and unused commands over s_axis. A behavioral copy
// of the table predicts every result, and each m_axis transaction is
// checked against the oldest prediction. Both sides idle at random.
// ---------------------------------------------------------------------------
module software_timer_table_top_tb;

    import stt_pkg::*;

    localparam int TIMER_SLOTS = DEFAULT_SLOTS;
    localparam real HALF_PERIOD = 6.0;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 250;

    // the fourth opcode has no meaning; the block must drop it silently
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic                success;
        logic [IDENT_W-1:0]  ident;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } timer_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // behavioral copy of the table: live timers in order of creation
    entry_t             live_timers[$];
    logic [IDENT_W-1:0] next_timer_id = '0;
    timer_result_t      pending_results[$];

    bit steady_flow = 1'b0;
    int stall_left = 0;
    int mismatches = 0;
    int results_checked = 0;
    int timers_fired = 0;
    int adds_sent = 0;
    int removes_sent = 0;
    int ticks_sent = 0;
    int unused_sent = 0;

    timer_result_t seen;
    timer_result_t want;

    software_timer_table_top #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------
    function automatic void queue_result(logic [1:0] kind, logic ok,
                                         logic [IDENT_W-1:0] ident,
                                         logic [HANDLE_W-1:0] handle, logic last);
        timer_result_t res;
        res.kind = kind;
        res.success = ok;
        res.ident = ident;
        res.handle = handle;
        res.last = last;
        pending_results.insert(pending_results.size(), res);
    endfunction

    function automatic void table_command(logic [1:0] op, logic [31:0] now,
                                          logic [31:0] ivl, logic per,
                                          logic [HANDLE_W-1:0] hnd,
                                          logic [31:0] tgt);
        entry_t      rec;
        int          idx;
        int          fired;
        logic [31:0] lag;
        case (op)
            OP_ADD:
            begin
                if (live_timers.size() >= TIMER_SLOTS)
                begin
                    // full table: refused, id counter holds
                    queue_result(KIND_ADD, 1'b0, '0, '0, 1'b1);
                end
                else
                begin
                    rec.periodic = per;
                    rec.interval = ivl;
                    rec.due = now + ivl;
                    rec.handle = hnd;
                    rec.ident = next_timer_id;
                    live_timers.insert(live_timers.size(), rec);
                    queue_result(KIND_ADD, 1'b1, next_timer_id, '0, 1'b1);
                    next_timer_id = next_timer_id + IDENT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                idx = -1;
                for (int i = 0; i < live_timers.size(); i++)
                begin
                    if (idx < 0 && live_timers[i].ident == tgt)
                        idx = i;
                end
                if (idx >= 0)
                    live_timers.delete(idx);
                queue_result(KIND_REMOVE, idx >= 0, '0, '0, 1'b1);
            end
            OP_TICK:
            begin
                fired = 0;
                idx = 0;
                while (idx < live_timers.size())
                begin
                    // due when the wrapping difference is not negative
                    lag = now - live_timers[idx].due;
                    if (!lag[31])
                    begin
                        queue_result(KIND_FIRED, 1'b1, live_timers[idx].ident,
                                     live_timers[idx].handle, 1'b0);
                        fired++;
                        if (live_timers[idx].periodic)
                        begin
                            live_timers[idx].due = now + live_timers[idx].interval;
                            idx++;
                        end
                        else
                        begin
                            live_timers.delete(idx);
                        end
                    end
                    else
                    begin
                        idx++;
                    end
                end
                if (fired == 0)
                    queue_result(KIND_NOFIRE, 1'b0, '0, '0, 1'b1);
                else
                    pending_results[pending_results.size() - 1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus side
    // -----------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // One transaction on s_axis; the prediction is taken at the accepting edge.
    // tvalid is only lowered inside the idle gap, so back-to-back commands
    // never see a low and a high in the same step.
    task automatic send_command(input logic [1:0] op, input logic [31:0] now,
                                input logic [31:0] ivl, input logic per,
                                input logic [HANDLE_W-1:0] hnd,
                                input logic [31:0] tgt);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tdata <= {tgt, hnd, per, ivl, now};
        s_axis_tuser <= op;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        table_command(op, now, ivl, per, hnd, tgt);
        case (op)
            OP_ADD:    adds_sent++;
            OP_REMOVE: removes_sent++;
            OP_TICK:   ticks_sent++;
            default:   unused_sent++;
        endcase
    endtask

    // -----------------------------------------------------------------------
    // Result side: random backpressure, short stalls mostly, a few long
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        int r;
        if (steady_flow)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b0;
                stall_left = (r < 94) ? $urandom_range(0, 2) : $urandom_range(10, 30);
            end
        end
    end

    // Checker: every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            seen.kind = m_axis_tuser;
            seen.success = m_axis_tdata[0];
            seen.ident = m_axis_tdata[32:1];
            seen.handle = m_axis_tdata[63:33];
            seen.last = m_axis_tlast;
            results_checked++;
            if (seen.kind == KIND_FIRED)
                timers_fired++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result kind=%0d ok=%0b id=%h handle=%h last=%0b",
                             $realtime, seen.kind, seen.success, seen.ident,
                             seen.handle, seen.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen.kind !== want.kind || seen.success !== want.success ||
                    seen.ident !== want.ident || seen.handle !== want.handle ||
                    seen.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch expected kind=%0d ok=%0b id=%h handle=%h last=%0b",
                                 $realtime, want.kind, want.success, want.ident,
                                 want.handle, want.last);
                        $display("    got kind=%0d ok=%0b id=%h handle=%h last=%0b",
                                 seen.kind, seen.success, seen.ident, seen.handle,
                                 seen.last);
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // empty table: tick with nothing live, dropped opcode, remove that misses
    task automatic test_empty_table();
        send_command(OP_TICK, 32'h0000_0000, $urandom, 1'($urandom), 31'($urandom),
                     $urandom);
        send_command(OP_UNUSED, $urandom, $urandom, 1'($urandom), 31'($urandom),
                     $urandom);
        send_command(OP_REMOVE, $urandom, $urandom, 1'($urandom), 31'($urandom),
                     32'h0000_0000);
    endtask

    // field extremes and the edges of the signed due comparison
    task automatic test_field_extremes();
        // due now, periodic, all-ones handle
        send_command(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 31'h7FFF_FFFF, '0);
        // due one ms in the past after wrap
        send_command(OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 31'h0000_0000, '1);
        // exactly half the range ahead of zero
        send_command(OP_ADD, 32'h0000_0000, 32'h8000_0000, 1'b1, 31'h2AAA_AAAA, '0);
        send_command(OP_ADD, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 31'h5555_5555, '0);
        send_command(OP_TICK, 32'hFFFF_FFFF, '1, 1'b1, '1, '1);
        // id 1 was one-shot and already fired
        send_command(OP_REMOVE, '1, '1, 1'b1, '1, 32'h0000_0001);
        send_command(OP_REMOVE, '0, '0, 1'b0, '0, 32'h0000_0000);
        send_command(OP_REMOVE, '0, '0, 1'b0, '0, 32'hFFFF_FFFF);
    endtask

    // fill every slot, overflow once, close a gap in the middle, fire those now due
    task automatic test_full_table();
        while (live_timers.size() < TIMER_SLOTS)
            send_command(OP_ADD, 32'd1000, $urandom_range(0, 15),
                         1'($urandom_range(0, 1)), 31'($urandom), $urandom);
        send_command(OP_ADD, 32'd1000, 32'd1, 1'b1, 31'($urandom), $urandom);
        send_command(OP_REMOVE, $urandom, $urandom, 1'($urandom), 31'($urandom),
                     live_timers[TIMER_SLOTS / 2].ident);
        send_command(OP_TICK, 32'd1010, $urandom, 1'($urandom), 31'($urandom),
                     $urandom);
    endtask

    // Mostly coherent traffic around a moving clock: adds with short delays,
    // removes of live ids, ticks stepping forward. Some far jumps, stale or
    // random ids, huge intervals and dropped opcodes mixed in.
    task automatic test_random_traffic(input int count);
        logic [31:0] clock_ms;
        logic [31:0] ivl;
        logic [31:0] stamp;
        logic [31:0] tgt;
        int          r;
        int          pick;
        clock_ms = $urandom;
        for (int n = 0; n < count; n++)
        begin
            // stretches with no idling at all on either side
            if (n % 40 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 36)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                    ivl = $urandom_range(0, 40);
                else if (pick < 9)
                    ivl = $urandom;
                else
                    ivl = 32'h7FFF_FFF0 + $urandom_range(0, 31);
                stamp = ($urandom_range(0, 9) == 0) ? $urandom : clock_ms;
                send_command(OP_ADD, stamp, ivl, 1'($urandom_range(0, 1)),
                             31'($urandom), $urandom);
            end
            else if (r < 52)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 14 && live_timers.size() > 0)
                    tgt = live_timers[$urandom_range(0, live_timers.size() - 1)].ident;
                else if (pick < 17)
                    tgt = next_timer_id - $urandom_range(0, 3);
                else
                    tgt = $urandom;
                send_command(OP_REMOVE, $urandom, $urandom, 1'($urandom),
                             31'($urandom), tgt);
            end
            else if (r < 97)
            begin
                if ($urandom_range(0, 24) == 0)
                    clock_ms = clock_ms + $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, 20);
                send_command(OP_TICK, clock_ms, $urandom, 1'($urandom),
                             31'($urandom), $urandom);
            end
            else
            begin
                send_command(OP_UNUSED, $urandom, $urandom, 1'($urandom),
                             31'($urandom), $urandom);
            end
        end
        steady_flow = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_field_extremes();
        test_full_table();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // anything arriving now has no prediction and is flagged by the checker
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Commands: %0d adds, %0d removes, %0d ticks, %0d unused opcodes",
                 adds_sent, removes_sent, ticks_sent, unused_sent);
        $display("Results checked: %0d, of which %0d timer firings; mismatches: %0d",
                 results_checked, timers_fired, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
